FILE: rtl/core/lscg_pkg.sv
// Shared types, constants and helpers for the least-squares cell gradient unit.
// No dependencies.
package lscg_pkg;

   localparam int DATA_W = 32;
   localparam int DV_W   = 33;
   localparam int WGT_W  = 31;
   localparam int ACC_W  = 64;
   localparam int EPS_W  = 16;
   localparam int NUM_INV = 6;

   localparam logic [WGT_W-1:0] WGT_MAX = '1;

   // One contribution, handed from the front end to the back end
   typedef struct packed {
      logic signed [DATA_W-1:0] rel_x;
      logic signed [DATA_W-1:0] rel_y;
      logic signed [DATA_W-1:0] rel_z;
      logic signed [DV_W-1:0]   dv;
      logic [WGT_W-1:0]         wgt;
      logic                     wgt_sat;
      logic                     last;
      logic [NUM_INV-1:0][DATA_W-1:0] inv;
   } contrib_type;

   // True when a 64-bit value lies in the signed 32-bit range
   function automatic logic fits32(input logic signed [ACC_W-1:0] v);
      fits32 = (v[ACC_W-1:DATA_W-1] == '0) || (v[ACC_W-1:DATA_W-1] == '1);
   endfunction

   // Clamp a 64-bit value to the signed 32-bit range
   function automatic logic signed [DATA_W-1:0] clip32(input logic signed [ACC_W-1:0] v);
      if (fits32(v)) begin
         clip32 = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         clip32 = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         clip32 = {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   // Entry of the symmetric inverse for a row and column (xx xy xz yy yz zz)
   function automatic logic [2:0] sym_index(input logic [1:0] r, input logic [1:0] c);
      logic [3:0] key;
      key = {r, c};
      case (key)
         4'b0000: sym_index = 3'd0;
         4'b0001, 4'b0100: sym_index = 3'd1;
         4'b0010, 4'b1000: sym_index = 3'd2;
         4'b0101: sym_index = 3'd3;
         4'b0110, 4'b1001: sym_index = 3'd4;
         default: sym_index = 3'd5;
      endcase
   endfunction

endpackage

FILE: rtl/core/lscg_front.sv
// Front end: accepts a transaction, forms |r|^2 + eps and the weight 1/d by
// restoring division. Depends on lscg_pkg.
module lscg_front import lscg_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [EPS_W-1:0]         small_value,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_rel_x,
   input  logic signed [DATA_W-1:0] req_rel_y,
   input  logic signed [DATA_W-1:0] req_rel_z,
   input  logic signed [DATA_W-1:0] req_neighbor_value,
   input  logic signed [DATA_W-1:0] req_cell_value,
   input  logic                     req_last,
   input  logic signed [DATA_W-1:0] req_inv_xx,
   input  logic signed [DATA_W-1:0] req_inv_xy,
   input  logic signed [DATA_W-1:0] req_inv_xz,
   input  logic signed [DATA_W-1:0] req_inv_yy,
   input  logic signed [DATA_W-1:0] req_inv_yz,
   input  logic signed [DATA_W-1:0] req_inv_zz,
   output logic                     push_valid,
   input  logic                     push_ready,
   output contrib_type              push_data
);

   localparam int DW = 65 - FRACTION_BITS;     // denominator width
   localparam int QW = 2 * FRACTION_BITS + 1;  // quotient width
   localparam int CW = $clog2(QW);

   typedef enum logic [1:0] {F_IDLE, F_SQ, F_DIV, F_PUSH} state_type;

   state_type              state_ff;
   contrib_type            item_ff;
   logic [1:0]             idx_ff;
   logic [ACC_W-1:0]       sq_ff;
   logic [DW-1:0]          den_ff;
   logic [DW-1:0]          rem_ff;
   logic [QW-1:0]          quo_ff;
   logic [CW-1:0]          cnt_ff;

   logic signed [DATA_W-1:0] sq_op;
   logic signed [ACC_W-1:0]  sq_prod;
   logic [DW-1:0]            den_in;
   logic [DW:0]              rem_sh;
   logic                     rem_ge;
   logic [QW-1:0]            quo_in;
   logic [ACC_W-1:0]         quo_wide;

   // one squaring multiplier shared over x, y, z
   always_comb begin
      case (idx_ff)
         2'd0:    sq_op = item_ff.rel_x;
         2'd1:    sq_op = item_ff.rel_y;
         default: sq_op = item_ff.rel_z;
      endcase
      sq_prod = ACC_W'(sq_op) * ACC_W'(sq_op);
   end

   // fold the final square in for the denominator
   assign den_in = DW'((sq_ff + sq_prod) >> FRACTION_BITS) + DW'(small_value);

   // one restoring division step; dividend is the single bit 2^(2F)
   always_comb begin
      rem_sh   = {rem_ff, (cnt_ff == CW'(2 * FRACTION_BITS))};
      rem_ge   = rem_sh >= {1'b0, den_ff};
      quo_in   = {quo_ff[QW-2:0], rem_ge};
      quo_wide = ACC_W'(quo_in);
   end

   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  item_ff.rel_x <= req_rel_x;
                  item_ff.rel_y <= req_rel_y;
                  item_ff.rel_z <= req_rel_z;
                  item_ff.dv    <= DV_W'(req_neighbor_value) - DV_W'(req_cell_value);
                  item_ff.last  <= req_last;
                  item_ff.inv   <= {req_inv_zz, req_inv_yz, req_inv_yy,
                                    req_inv_xz, req_inv_xy, req_inv_xx};
                  idx_ff        <= 2'd0;
                  sq_ff         <= '0;
                  state_ff      <= F_SQ;
               end
            end
            F_SQ: begin
               sq_ff  <= sq_ff + sq_prod;
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  state_ff <= F_DIV;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= CW'(QW - 1);
                  den_ff   <= den_in;
               end
            end
            F_DIV: begin
               if (den_ff == '0) begin
                  // zero denominator: weight pinned to max and flagged
                  item_ff.wgt     <= WGT_MAX;
                  item_ff.wgt_sat <= 1'b1;
                  state_ff        <= F_PUSH;
               end else begin
                  rem_ff <= rem_ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
                  quo_ff <= quo_in;
                  cnt_ff <= cnt_ff - 1'b1;
                  if (cnt_ff == '0) begin
                     if (quo_wide > ACC_W'(WGT_MAX)) begin
                        item_ff.wgt     <= WGT_MAX;
                        item_ff.wgt_sat <= 1'b1;
                     end else begin
                        item_ff.wgt     <= quo_wide[WGT_W-1:0];
                        item_ff.wgt_sat <= 1'b0;
                     end
                     state_ff <= F_PUSH;
                  end
               end
            end
            F_PUSH: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/core/lscg_queue.sv
// Two-entry queue between front and back ends.
// Depends on lscg_pkg.
module lscg_queue import lscg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  contrib_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output contrib_type out_data
);

   contrib_type mem_ff [2];
   logic        wr_ff;
   logic        rd_ff;
   logic [1:0]  count_ff;
   logic        do_push;
   logic        do_pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop)  rd_ff <= ~rd_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

FILE: rtl/core/lscg_back.sv
// Back end: weighted accumulation, inverse-matrix product and result register.
// Depends on lscg_pkg.
module lscg_back import lscg_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  contrib_type              pop_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_grad_x,
   output logic signed [DATA_W-1:0] rsp_grad_y,
   output logic signed [DATA_W-1:0] rsp_grad_z,
   output logic                     rsp_overflow
);

   typedef enum logic [2:0] {B_IDLE, B_WEIGHT, B_ACC, B_BOUND, B_MAT, B_OUT} state_type;

   state_type                 state_ff;
   contrib_type               item_ff;
   logic signed [ACC_W-1:0]   acc_ff [3];
   logic signed [DATA_W-1:0]  bnd_ff [3];
   logic signed [DATA_W-1:0]  grad_ff [3];
   logic signed [DATA_W-1:0]  t_ff;
   logic signed [ACC_W-1:0]   rsum_ff;
   logic                      sat_seen_ff;
   logic [1:0]                idx_ff;
   logic [1:0]                row_ff;
   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  rsp_x_ff;
   logic signed [DATA_W-1:0]  rsp_y_ff;
   logic signed [DATA_W-1:0]  rsp_z_ff;
   logic                      rsp_ovf_ff;

   logic signed [64:0]        wdv;
   logic signed [ACC_W-1:0]   wdv_sh;
   logic signed [DATA_W-1:0]  r_op;
   logic signed [ACC_W-1:0]   tr_sh;
   logic signed [ACC_W:0]     acc_sum;
   logic                      acc_ovf;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [DATA_W-1:0]  inv_op;
   logic signed [ACC_W-1:0]   mat_prod;
   logic signed [ACC_W-1:0]   rsum_in;

   // weight times value difference
   always_comb begin
      wdv    = 65'($signed({1'b0, item_ff.wgt})) * 65'(item_ff.dv);
      wdv_sh = ACC_W'(wdv >>> FRACTION_BITS);
   end

   // contribution to one accumulator, saturating add
   always_comb begin
      case (idx_ff)
         2'd0:    r_op = item_ff.rel_x;
         2'd1:    r_op = item_ff.rel_y;
         default: r_op = item_ff.rel_z;
      endcase
      tr_sh   = (ACC_W'(t_ff) * ACC_W'(r_op)) >>> FRACTION_BITS;
      acc_sum = (ACC_W+1)'(acc_ff[idx_ff]) + (ACC_W+1)'(tr_sh);
      acc_ovf = acc_sum[ACC_W] != acc_sum[ACC_W-1];
      if (!acc_ovf) begin
         acc_in = acc_sum[ACC_W-1:0];
      end else if (acc_sum[ACC_W]) begin
         acc_in = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         acc_in = {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

   // one term of the matrix-vector product
   always_comb begin
      inv_op   = item_ff.inv[sym_index(row_ff, idx_ff)];
      mat_prod = (ACC_W'(inv_op) * ACC_W'(bnd_ff[idx_ff])) >>> FRACTION_BITS;
      rsum_in  = rsum_ff + mat_prod;
   end

   assign pop_ready    = (state_ff == B_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_grad_x   = rsp_x_ff;
   assign rsp_grad_y   = rsp_y_ff;
   assign rsp_grad_z   = rsp_z_ff;
   assign rsp_overflow = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         sat_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  item_ff  <= pop_data;
                  state_ff <= B_WEIGHT;
               end
            end
            B_WEIGHT: begin
               t_ff        <= clip32(wdv_sh);
               sat_seen_ff <= sat_seen_ff | item_ff.wgt_sat | ~fits32(wdv_sh);
               idx_ff      <= 2'd0;
               state_ff    <= B_ACC;
            end
            B_ACC: begin
               acc_ff[idx_ff] <= acc_in;
               sat_seen_ff    <= sat_seen_ff | acc_ovf;
               idx_ff         <= idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  state_ff <= item_ff.last ? B_BOUND : B_IDLE;
               end
            end
            B_BOUND: begin
               for (int i = 0; i < 3; i++) bnd_ff[i] <= clip32(acc_ff[i]);
               sat_seen_ff <= sat_seen_ff | ~fits32(acc_ff[0]) | ~fits32(acc_ff[1])
                              | ~fits32(acc_ff[2]);
               idx_ff   <= 2'd0;
               row_ff   <= 2'd0;
               rsum_ff  <= '0;
               state_ff <= B_MAT;
            end
            B_MAT: begin
               if (idx_ff == 2'd2) begin
                  grad_ff[row_ff] <= clip32(rsum_in);
                  sat_seen_ff     <= sat_seen_ff | ~fits32(rsum_in);
                  rsum_ff         <= '0;
                  idx_ff          <= 2'd0;
                  row_ff          <= row_ff + 2'd1;
                  if (row_ff == 2'd2) state_ff <= B_OUT;
               end else begin
                  rsum_ff <= rsum_in;
                  idx_ff  <= idx_ff + 2'd1;
               end
            end
            B_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= grad_ff[0];
                  rsp_y_ff     <= grad_ff[1];
                  rsp_z_ff     <= grad_ff[2];
                  rsp_ovf_ff   <= sat_seen_ff;
                  sat_seen_ff  <= 1'b0;
                  for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/core/least_squares_cell_gradient_unit.sv
// Least-squares cell gradient unit: top level tying front end, queue, back end.
// Depends on lscg_pkg, lscg_front, lscg_queue, lscg_back.
//
// One transaction per neighbor or boundary face; the transaction marked last
// returns the cell's gradient (Q format with FRACTION_BITS fraction bits) and
// an overflow flag. The front end steps through each transaction in turn
// (accept, three squarings on one multiplier, a one-bit-per-cycle weight
// divider, then the handoff); on a last transaction the back end adds
// clamping, the 3x3 product done one term per cycle and loading the result
// register. The front-end divider sets the sustained rate. A two-entry queue
// lets the front end start the next transaction while the back end works.
// small_value may be rewritten only when the unit is idle.
module least_squares_cell_gradient_unit import lscg_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [EPS_W-1:0]         csr_small_value,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_rel_x,
   input  logic signed [DATA_W-1:0] req_rel_y,
   input  logic signed [DATA_W-1:0] req_rel_z,
   input  logic signed [DATA_W-1:0] req_neighbor_value,
   input  logic signed [DATA_W-1:0] req_cell_value,
   input  logic                     req_last,
   input  logic signed [DATA_W-1:0] req_inv_xx,
   input  logic signed [DATA_W-1:0] req_inv_xy,
   input  logic signed [DATA_W-1:0] req_inv_xz,
   input  logic signed [DATA_W-1:0] req_inv_yy,
   input  logic signed [DATA_W-1:0] req_inv_yz,
   input  logic signed [DATA_W-1:0] req_inv_zz,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_grad_x,
   output logic signed [DATA_W-1:0] rsp_grad_y,
   output logic signed [DATA_W-1:0] rsp_grad_z,
   output logic                     rsp_overflow
);

   logic [EPS_W-1:0] small_value_ff;
   logic             push_valid;
   logic             push_ready;
   contrib_type      push_data;
   logic             pop_valid;
   logic             pop_ready;
   contrib_type      pop_data;

   // epsilon register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         small_value_ff <= EPS_W'(1);
      end else if (csr_valid) begin
         small_value_ff <= csr_small_value;
      end
   end

   lscg_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .small_value        (small_value_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rel_x          (req_rel_x),
      .req_rel_y          (req_rel_y),
      .req_rel_z          (req_rel_z),
      .req_neighbor_value (req_neighbor_value),
      .req_cell_value     (req_cell_value),
      .req_last           (req_last),
      .req_inv_xx         (req_inv_xx),
      .req_inv_xy         (req_inv_xy),
      .req_inv_xz         (req_inv_xz),
      .req_inv_yy         (req_inv_yy),
      .req_inv_yz         (req_inv_yz),
      .req_inv_zz         (req_inv_zz),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_data          (push_data)
   );

   lscg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   lscg_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_grad_x   (rsp_grad_x),
      .rsp_grad_y   (rsp_grad_y),
      .rsp_grad_z   (rsp_grad_z),
      .rsp_overflow (rsp_overflow)
   );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for least_squares_cell_gradient_unit: random cells of
// contributions, each closed by a last transaction; gradients checked in order.
// Depends on lscg_pkg and the RTL of the unit.
module testbench;
   import lscg_pkg::*;

   localparam int FB = 16;
   localparam int CYCLE_LIMIT = 800000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic signed [DATA_W-1:0] rx, ry, rz, nv, cv;
      logic                     last;
      logic signed [DATA_W-1:0] ixx, ixy, ixz, iyy, iyz, izz;
   } contrib_t;

   typedef struct {
      logic signed [DATA_W-1:0] gx, gy, gz;
      logic                     ovf;
   } grad_t;

   // Gradient predictor and store of pending gradients
   class gradient_board;
      longint acc_x, acc_y, acc_z;
      bit     sat_seen;
      logic [EPS_W-1:0] eps;
      grad_t  pending[$];
      int     errors;

      function new();
         acc_x = 0; acc_y = 0; acc_z = 0; sat_seen = 0; eps = 1; errors = 0;
      endfunction

      function longint clamp32(longint v, inout bit f);
         if (v > 64'sh7FFF_FFFF) begin f = 1; return 64'sh7FFF_FFFF; end
         if (v < -64'sh8000_0000) begin f = 1; return -64'sh8000_0000; end
         return v;
      endfunction

      function longint add_sat(longint a, longint b, inout bit f);
         longint hi, lo;
         hi = 64'sh7FFF_FFFF_FFFF_FFFF;
         lo = 64'sh8000_0000_0000_0000;
         if (b > 0 && a > hi - b) begin f = 1; return hi; end
         if (b < 0 && a < lo - b) begin f = 1; return lo; end
         return a + b;
      endfunction

      function longint row(longint a, longint b, longint c,
                           longint x, longint y, longint z, inout bit f);
         longint s;
         s = ((a * x) >>> FB) + ((b * y) >>> FB) + ((c * z) >>> FB);
         return clamp32(s, f);
      endfunction

      // Accepted contribution: accumulate, and predict a gradient on last
      function void note(contrib_t c);
         longint rx, ry, rz, dv, t, bx, by, bz;
         logic [63:0] sq, d, w;
         bit f;
         grad_t g;
         rx = longint'(c.rx); ry = longint'(c.ry); rz = longint'(c.rz);
         dv = longint'(c.nv) - longint'(c.cv);
         f = sat_seen;
         sq = 64'(rx * rx) + 64'(ry * ry) + 64'(rz * rz);
         d = (sq >> FB) + 64'(eps);
         if (d == 0) begin
            w = 64'h7FFF_FFFF; f = 1;
         end else begin
            w = (64'd1 << (2 * FB)) / d;
            if (w > 64'h7FFF_FFFF) begin w = 64'h7FFF_FFFF; f = 1; end
         end
         t = clamp32((longint'(w) * dv) >>> FB, f);
         acc_x = add_sat(acc_x, (t * rx) >>> FB, f);
         acc_y = add_sat(acc_y, (t * ry) >>> FB, f);
         acc_z = add_sat(acc_z, (t * rz) >>> FB, f);
         sat_seen = f;
         if (!c.last) return;
         bx = clamp32(acc_x, f);
         by = clamp32(acc_y, f);
         bz = clamp32(acc_z, f);
         g.gx = 32'(row(c.ixx, c.ixy, c.ixz, bx, by, bz, f));
         g.gy = 32'(row(c.ixy, c.iyy, c.iyz, bx, by, bz, f));
         g.gz = 32'(row(c.ixz, c.iyz, c.izz, bx, by, bz, f));
         g.ovf = f;
         pending.push_back(g);
         acc_x = 0; acc_y = 0; acc_z = 0; sat_seen = 0;
      endfunction

      // Accepted gradient against the oldest prediction
      function void check(grad_t a);
         grad_t e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected gradient %0d %0d %0d ovf %0b",
                                       a.gx, a.gy, a.gz, a.ovf);
            return;
         end
         e = pending.pop_front();
         if (a.gx !== e.gx || a.gy !== e.gy || a.gz !== e.gz || a.ovf !== e.ovf) begin
            errors++;
            if (errors <= 10)
               $display("gradient exp %0d %0d %0d ovf %0b, got %0d %0d %0d ovf %0b",
                        e.gx, e.gy, e.gz, e.ovf, a.gx, a.gy, a.gz, a.ovf);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [EPS_W-1:0] csr_small_value = 0;
   logic req_valid = 0;
   logic req_ready;
   contrib_t cur;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [DATA_W-1:0] rsp_grad_x, rsp_grad_y, rsp_grad_z;
   logic rsp_overflow;

   logic rcv_open = 0;
   logic hold_off = 0;
   int   rcv_wait = 0;
   bit   rcv_quiet = 0;
   int   cycles = 0;
   int   n_sent = 0;
   gradient_board board = new();

   assign rsp_ready = rcv_open & ~hold_off;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   least_squares_cell_gradient_unit #(.FRACTION_BITS(FB)) u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_small_value(csr_small_value),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_rel_x(cur.rx), .req_rel_y(cur.ry), .req_rel_z(cur.rz),
      .req_neighbor_value(cur.nv), .req_cell_value(cur.cv), .req_last(cur.last),
      .req_inv_xx(cur.ixx), .req_inv_xy(cur.ixy), .req_inv_xz(cur.ixz),
      .req_inv_yy(cur.iyy), .req_inv_yz(cur.iyz), .req_inv_zz(cur.izz),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_grad_x(rsp_grad_x), .rsp_grad_y(rsp_grad_y), .rsp_grad_z(rsp_grad_z),
      .rsp_overflow(rsp_overflow)
   );

   // Monitors: transactions on all three channels
   always @(posedge clock) begin
      grad_t a;
      if (!reset && csr_valid && csr_ready) board.eps = csr_small_value;
      if (!reset && req_valid && req_ready) begin
         board.note(cur);
         n_sent++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         a.gx = rsp_grad_x; a.gy = rsp_grad_y; a.gz = rsp_grad_z; a.ovf = rsp_overflow;
         board.check(a);
         rcv_wait = rcv_quiet ? 0 : $urandom_range(0, 6);
      end
   end

   // Receiver stalls
   always @(negedge clock) begin
      if (rcv_wait > 0) begin
         rcv_open <= 0;
         rcv_wait--;
      end else begin
         rcv_open <= 1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("least_squares_cell_gradient_unit: mismatch");
         $finish;
      end
   end

   // Long receiver hold-off so the queue fills and the input stalls
   initial begin
      wait (n_sent >= 300);
      @(negedge clock);
      hold_off <= 1;
      repeat (1500) @(negedge clock);
      hold_off <= 0;
   end

   // One contribution: optional gap, then offer until accepted
   task automatic push(contrib_t c, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      cur <= c;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_eps(logic [EPS_W-1:0] v);
      req_valid <= 0;
      wait (board.pending.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_small_value <= v;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         2: return 0;
         3: return $signed($urandom_range(0, 255)) - 128;
         default: return $signed($urandom_range(0, 8 << FB)) - (4 << FB);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         default: return $signed($urandom_range(0, 200 << FB)) - (100 << FB);
      endcase
   endfunction

   function automatic contrib_t rand_contrib(bit last, logic signed [31:0] cell_val);
      contrib_t c;
      c.rx = rand_coord(); c.ry = rand_coord(); c.rz = rand_coord();
      c.nv = rand_value();
      c.cv = ($urandom_range(0, 9) == 0) ? rand_value() : cell_val;
      c.last = last;
      c.ixx = rand_coord(); c.ixy = rand_coord(); c.ixz = rand_coord();
      c.iyy = rand_coord(); c.iyz = rand_coord(); c.izz = rand_coord();
      return c;
   endfunction

   function automatic contrib_t mk(logic signed [31:0] r, logic signed [31:0] nv,
                                   logic signed [31:0] cv, bit last,
                                   logic signed [31:0] inv);
      contrib_t c;
      c.rx = r; c.ry = r; c.rz = r; c.nv = nv; c.cv = cv; c.last = last;
      c.ixx = inv; c.ixy = inv; c.ixz = inv; c.iyy = inv; c.iyz = inv; c.izz = inv;
      return c;
   endfunction

   // Random cells until the phase has seen n contributions
   task automatic run_cells(int n);
      int k, len;
      logic signed [31:0] cell_val;
      k = 0;
      while (k < n) begin
         len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
         cell_val = rand_value();
         for (int i = 0; i < len; i++) begin
            push(rand_contrib(i == len - 1, cell_val), $urandom_range(0, 3) == 0 ? 0 :
                 $urandom_range(0, 6));
            k++;
         end
      end
   endtask

   initial begin
      contrib_t c;
      cur = mk(0, 0, 0, 0, 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: reset epsilon, tiny denominator, extremes, non-last inverse ignored
      push(mk(0, 32'sh0001_0000, 0, 1, 32'sh0001_0000), 0);
      push(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh7FFF_FFFF), 0);
      push(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 32'sh8000_0000), 1);
      push(mk(32'sh0001_0000, 32'sh0003_0000, 32'sh0001_0000, 0, 32'sh7FFF_FFFF), 0);
      push(mk(-32'sh0002_0000, 32'sh0000_8000, 32'sh0001_0000, 0, 32'sh8000_0000), 2);
      c = mk(32'sh0000_4000, -32'sh0005_0000, 32'sh0001_0000, 1, 32'sh0000_8000);
      c.ry = -32'sh0001_0000; c.iyy = -32'sh0002_0000;
      push(c, 0);
      push(mk(1, 32'sh0000_0100, 0, 1, 32'sh0001_0000), 3);
      push(mk(-1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, -1), 0);
      run_cells(160);

      // Zero epsilon: zero denominator case first
      write_eps(0);
      push(mk(0, 32'sh0001_0000, 0, 1, 32'sh0001_0000), 0);
      push(mk(0, 0, 0, 0, 0), 0);
      push(mk(32'sh0001_0000, 32'sh0002_0000, 0, 1, 32'sh0001_0000), 0);
      run_cells(160);

      write_eps(16'hFFFF);
      push(mk(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 32'sh7FFF_FFFF), 0);
      rcv_quiet = 1;
      run_cells(160);
      rcv_quiet = 0;

      write_eps($urandom_range(1, 16'hFFFE));
      run_cells(200);

      write_eps($urandom_range(0, 16'hFF));
      run_cells(200);
      req_valid <= 0;

      wait (board.pending.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("least_squares_cell_gradient_unit: match");
      end else begin
         $display("least_squares_cell_gradient_unit: mismatch");
      end
      $finish;
   end

endmodule
